FILE: hw/rtl/bsw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsw_pkg;

  // Widths of the fixed fields.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned PosW     = 15;  // signed column and row positions
  localparam int unsigned ErrW     = 15;  // signed error terms

  // Input operation codes.
  localparam logic OP_START = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // Pixel formats.
  localparam logic [1:0] FMT_1BPP = 2'd0;
  localparam logic [1:0] FMT_4BPP = 2'd1;
  localparam logic [1:0] FMT_8BPP = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_SRC_WIDTH     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SRC_HEIGHT    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BITMAP_HEIGHT = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DST_WIDTH     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DST_HEIGHT    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SRC_X         = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_SRC_Y         = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_PIXEL_FORMAT  = 3'd7;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_XLOOP = 4'b0010,
    S_YLOOP = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;     // latch setup and restart the walk
    logic idle_pix;  // pixel transaction while no walk is running
    logic pixel;     // capture a pixel and advance the column counter
    logic x_step;    // one step of the column error loop
    logic y_step;    // one step of the row error loop
    logic load_out;  // move the pending result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic active;    // a walk is running
    logic row_end;   // the pixel about to be captured ends its row
    logic x_finish;  // column loop is on its last step
    logic y_finish;  // row loop is on its last step
    logic out_free;  // output register can take a result this cycle
  } sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bsw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bsw_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  input  wire logic          op,
  output logic               item_stall,
  input  wire bsw_pkg::sts_t sts,
  output bsw_pkg::cmd_t      cmd
);

  bsw_pkg::state_t state, state_next;
  logic accept;

  assign item_stall = (state != bsw_pkg::S_IDLE);
  assign accept     = item_valid && (state == bsw_pkg::S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      bsw_pkg::S_IDLE: begin
        if (accept) begin
          if (op == bsw_pkg::OP_START) begin
            cmd.start  = 1'b1;
            state_next = bsw_pkg::S_EMIT;
          end else if (!sts.active) begin
            cmd.idle_pix = 1'b1;
            state_next   = bsw_pkg::S_EMIT;
          end else begin
            cmd.pixel  = 1'b1;
            state_next = sts.row_end ? bsw_pkg::S_YLOOP : bsw_pkg::S_XLOOP;
          end
        end
      end
      bsw_pkg::S_XLOOP: begin
        cmd.x_step = 1'b1;
        if (sts.x_finish) begin
          state_next = bsw_pkg::S_EMIT;
        end
      end
      bsw_pkg::S_YLOOP: begin
        cmd.y_step = 1'b1;
        if (sts.y_finish) begin
          state_next = bsw_pkg::S_EMIT;
        end
      end
      bsw_pkg::S_EMIT: begin
        cmd.load_out = sts.out_free;
        if (sts.out_free) begin
          state_next = bsw_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bsw_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsw_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/bsw_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module bsw_datapath #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [bsw_pkg::CfgIdxW-1:0]     cfg_index,
  input  wire logic [bsw_pkg::CfgDataW-1:0]    cfg_data,
  input  wire logic [7:0]                      source_byte,
  input  wire bsw_pkg::cmd_t                   cmd,
  output bsw_pkg::sts_t                        sts,
  input  wire logic                            result_stall,
  output logic                                 result_valid,
  output logic                                 pixel_valid,
  output logic [7:0]                           color,
  output logic [11:0]                          dest_x,
  output logic [11:0]                          dest_y,
  output logic [11:0]                          fetch_row,
  output logic [11:0]                          fetch_byte,
  output logic                                 last
);

  localparam int unsigned PW = bsw_pkg::PosW;
  localparam int unsigned EW = bsw_pkg::ErrW;
  localparam int unsigned SatW = PW + 2;
  localparam logic [SatW-1:0] CoordMax = SatW'((64'd1 << COORD_BITS) - 64'd1);

  // Configuration registers.
  logic [11:0]        src_width, src_height, bitmap_height, src_x, src_y;
  logic signed [12:0] dst_width, dst_height;
  logic [1:0]         pixel_format;

  // Setup latched at the start of a walk.
  logic [12:0] dw, dh, sw2, sh2;
  logic [11:0] col0;
  logic        xm, ym;
  logic [1:0]  fmt;

  // Walk state.
  logic signed [PW-1:0] col, row;
  logic [11:0]          rows_left;
  logic signed [EW-1:0] x_err, y_err;
  logic [12:0]          out_x, out_y;
  logic                 active;

  // Pending result.
  logic        p_valid, p_last;
  logic [7:0]  p_color;
  logic [11:0] p_dx, p_dy;

  // Start values computed from the configuration registers.
  logic               st_xm, st_ym;
  logic [12:0]        st_dw, st_dh, st_sw2, st_sh2;
  logic signed [13:0] st_col0_raw;
  logic [11:0]        st_col0;
  logic signed [PW-1:0] st_row;

  always_comb begin
    st_xm  = dst_width[12];
    st_ym  = dst_height[12];
    st_dw  = st_xm ? 13'(-dst_width) : 13'(dst_width);
    st_dh  = st_ym ? 13'(-dst_height) : 13'(dst_height);
    st_sw2 = {src_width, 1'b0};
    st_sh2 = {src_height, 1'b0};
    if (st_xm) begin
      st_col0_raw = $signed({2'b00, src_width}) - $signed({2'b00, src_x}) - 14'sd1;
    end else begin
      st_col0_raw = $signed({2'b00, src_x});
    end
    st_col0 = st_col0_raw[13] ? 12'd0 : st_col0_raw[11:0];
    if (st_ym) begin
      st_row = $signed({3'b000, src_y});
    end else begin
      st_row = $signed({3'b000, bitmap_height}) - $signed({3'b000, src_y})
               - PW'(1);
    end
  end

  // Row and step helpers.
  logic [12:0]          out_x_inc, out_y_inc;
  logic                 row_end;
  logic signed [EW-1:0] x_err_row0, dw2, dh2, sw2_e, sh2_e;
  logic signed [PW-1:0] col_stepped, row_stepped;

  always_comb begin
    out_x_inc   = out_x + 13'd1;
    out_y_inc   = out_y + 13'd1;
    row_end     = (out_x_inc >= dw);
    sw2_e       = $signed({2'b00, sw2});
    sh2_e       = $signed({2'b00, sh2});
    dw2         = $signed({1'b0, dw, 1'b0});
    dh2         = $signed({1'b0, dh, 1'b0});
    x_err_row0  = sw2_e - $signed({2'b00, dw});
    col_stepped = xm ? (col - PW'(1)) : (col + PW'(1));
    if (col_stepped[PW-1]) begin
      col_stepped = '0;
    end
    row_stepped = ym ? (row + PW'(1)) : (row - PW'(1));
  end

  // Unpack the pixel at the current column.
  logic [7:0] unpacked;

  always_comb begin
    case (fmt)
      bsw_pkg::FMT_1BPP: unpacked = source_byte[3'd7 - col[2:0]] ? 8'h0F : 8'h00;
      bsw_pkg::FMT_4BPP: unpacked = col[0] ? {4'h0, source_byte[3:0]}
                                           : {4'h0, source_byte[7:4]};
      default:           unpacked = source_byte;
    endcase
  end

  // Fetch position of the next byte, saturated to the coordinate range.
  function automatic logic [11:0] sat_coord(input logic signed [PW-1:0] v);
    logic [SatW-1:0] wide;
    logic [SatW-1:0] clipped;
    wide    = {2'b00, v};
    clipped = (wide > CoordMax) ? CoordMax : wide;
    if (v[PW-1]) begin
      clipped = '0;
    end
    return clipped[11:0];
  endfunction

  logic signed [PW-1:0] byte_pos;
  logic [11:0]          fetch_row_calc, fetch_byte_calc;

  always_comb begin
    case (fmt)
      bsw_pkg::FMT_1BPP: byte_pos = $signed({3'b000, col[PW-1:3]});
      bsw_pkg::FMT_4BPP: byte_pos = $signed({1'b0, col[PW-1:1]});
      default:           byte_pos = col;
    endcase
    fetch_row_calc  = active ? sat_coord(row) : 12'd0;
    fetch_byte_calc = active ? sat_coord(byte_pos) : 12'd0;
  end

  assign sts.active   = active;
  assign sts.row_end  = row_end;
  assign sts.x_finish = x_err[EW-1];
  assign sts.y_finish = y_err[EW-1] || (rows_left <= 12'd1);
  assign sts.out_free = !result_valid || !result_stall;

  // Control state: configuration, walk activity, last mark, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width     <= 12'd1;
      src_height    <= 12'd1;
      bitmap_height <= 12'd1;
      dst_width     <= 13'sd1;
      dst_height    <= 13'sd1;
      src_x         <= 12'd0;
      src_y         <= 12'd0;
      pixel_format  <= bsw_pkg::FMT_8BPP;
      active        <= 1'b0;
      p_last        <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          bsw_pkg::REG_SRC_WIDTH:     src_width     <= cfg_data[11:0];
          bsw_pkg::REG_SRC_HEIGHT:    src_height    <= cfg_data[11:0];
          bsw_pkg::REG_BITMAP_HEIGHT: bitmap_height <= cfg_data[11:0];
          bsw_pkg::REG_DST_WIDTH:     dst_width     <= $signed(cfg_data);
          bsw_pkg::REG_DST_HEIGHT:    dst_height    <= $signed(cfg_data);
          bsw_pkg::REG_SRC_X:         src_x         <= cfg_data[11:0];
          bsw_pkg::REG_SRC_Y:         src_y         <= cfg_data[11:0];
          bsw_pkg::REG_PIXEL_FORMAT:  pixel_format  <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (cmd.start) begin
        active <= (st_dw != 13'd0) && (st_dh != 13'd0);
        p_last <= 1'b0;
      end else if (cmd.idle_pix || cmd.pixel) begin
        p_last <= 1'b0;
      end else if (cmd.y_step) begin
        if (!y_err[EW-1]) begin
          if (rows_left <= 12'd1) begin
            active <= 1'b0;
            p_last <= 1'b1;
          end
        end else if (out_y_inc >= dh) begin
          active <= 1'b0;
          p_last <= 1'b1;
        end
      end
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload state: setup, walk counters, pending and output result fields.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dw        <= st_dw;
      dh        <= st_dh;
      sw2       <= st_sw2;
      sh2       <= st_sh2;
      xm        <= st_xm;
      ym        <= st_ym;
      fmt       <= pixel_format;
      col0      <= st_col0;
      col       <= $signed({3'b000, st_col0});
      row       <= st_row;
      rows_left <= src_height;
      x_err     <= $signed({2'b00, st_sw2}) - $signed({2'b00, st_dw});
      y_err     <= $signed({2'b00, st_sh2}) - $signed({2'b00, st_dh});
      out_x     <= 13'd0;
      out_y     <= 13'd0;
      p_valid   <= 1'b0;
      p_color   <= 8'd0;
      p_dx      <= 12'd0;
      p_dy      <= 12'd0;
    end else if (cmd.idle_pix) begin
      p_valid <= 1'b0;
      p_color <= 8'd0;
      p_dx    <= 12'd0;
      p_dy    <= 12'd0;
    end else if (cmd.pixel) begin
      p_valid <= 1'b1;
      p_color <= unpacked;
      p_dx    <= out_x[11:0];
      p_dy    <= out_y[11:0];
      if (row_end) begin
        out_x <= 13'd0;
        col   <= $signed({3'b000, col0});
        x_err <= x_err_row0;
      end else begin
        out_x <= out_x_inc;
      end
    end else if (cmd.x_step) begin
      if (!x_err[EW-1]) begin
        col   <= col_stepped;
        x_err <= x_err - dw2;
      end else begin
        x_err <= x_err + sw2_e;
      end
    end else if (cmd.y_step) begin
      if (!y_err[EW-1]) begin
        if (rows_left > 12'd1) begin
          rows_left <= rows_left - 12'd1;
          row       <= row_stepped;
          y_err     <= y_err - dh2;
        end
      end else begin
        y_err <= y_err + sh2_e;
        out_y <= out_y_inc;
      end
    end
    if (cmd.load_out) begin
      pixel_valid <= p_valid;
      color       <= p_color;
      dest_x      <= p_dx;
      dest_y      <= p_dy;
      fetch_row   <= fetch_row_calc;
      fetch_byte  <= fetch_byte_calc;
      last        <= p_last;
    end
  end

  // The walk only stops on its own together with a last mark.
  assert property (@(posedge clk) disable iff (rst)
    $fell(active) && !$past(cmd.start) |-> p_last)
    else $error("walk went idle without a last mark");

  // A last mark only ever travels with a real pixel.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> pixel_valid && fetch_row == 12'd0 && fetch_byte == 12'd0)
    else $error("last mark on a non-pixel result or with a fetch position");

  // The column counter never reaches the destination width while walking.
  assert property (@(posedge clk) disable iff (rst)
    active && !cmd.start |-> out_x < dw)
    else $error("column counter ran past the destination width");

  // A loaded result is presented in the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> result_valid)
    else $error("loaded result not presented");

endmodule

`default_nettype wire

FILE: hw/rtl/bitmap_stretch_pixel_walker.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                   Payload
// item      in         item_valid / item_stall     op, source_byte
// result    out        result_valid / result_stall pixel_valid, color, dest_x, dest_y,
//                                                  fetch_row, fetch_byte, last
// config    in         cfg_wr_en                   cfg_index, cfg_data
//
// A start transaction, or a pixel transaction with no walk running, goes straight to emit.
// A pixel transaction inside a row first runs the column error loop over the source
// columns it skips; one that ends a row runs the row error loop over the source rows
// it consumes instead, each loop advancing one step per cycle.
// Reset is synchronous and active high; it restores the register defaults and idles.
// A stalled result blocks the handoff of the next finished result; intake stalls meanwhile.

module bitmap_stretch_pixel_walker #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Configuration write port.
  input  wire logic                         cfg_wr_en,
  input  wire logic [bsw_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [bsw_pkg::CfgDataW-1:0] cfg_data,
  // Input item channel.
  input  wire logic                         item_valid,
  output logic                              item_stall,
  input  wire logic                         op,
  input  wire logic [7:0]                   source_byte,
  // Result channel.
  output logic                              result_valid,
  input  wire logic                         result_stall,
  output logic                              pixel_valid,
  output logic [7:0]                        color,
  output logic [11:0]                       dest_x,
  output logic [11:0]                       dest_y,
  output logic [11:0]                       fetch_row,
  output logic [11:0]                       fetch_byte,
  output logic                              last
);

  // The controller sequences each transaction; the datapath holds the
  // configuration, the latched walk setup, the error terms and the result.
  bsw_pkg::cmd_t cmd;
  bsw_pkg::sts_t sts;

  bsw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .op         (op),
    .item_stall (item_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  bsw_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .source_byte  (source_byte),
    .cmd          (cmd),
    .sts          (sts),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .pixel_valid  (pixel_valid),
    .color        (color),
    .dest_x       (dest_x),
    .dest_y       (dest_y),
    .fetch_row    (fetch_row),
    .fetch_byte   (fetch_byte),
    .last         (last)
  );

endmodule

`default_nettype wire

FILE: tb/bitmap_stretch_pixel_walker_test.sv
`timescale 1ns / 1ps

module bitmap_stretch_pixel_walker_test;

  // The reserved format code behaves like eight bits per pixel.
  localparam logic [1:0] FMT_RESERVED = 2'd3;

  localparam int COORD_MAX      = 4095;
  localparam int RANDOM_ITEMS   = 1400;
  // The longest correct transaction skips about 4095 columns or consumes about 4095
  // rows, one loop step per cycle, and the receiver may stall on top of that.
  localparam int WATCHDOG_LIMIT = 40000;

  // One result transaction, in the order of the result ports.
  typedef struct packed {
    logic        pixel_valid;
    logic [7:0]  color;
    logic [11:0] dest_x;
    logic [11:0] dest_y;
    logic [11:0] fetch_row;
    logic [11:0] fetch_byte;
    logic        last;
  } pixel_result_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_wr_en = 1'b0;
  logic [bsw_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [bsw_pkg::CfgDataW-1:0] cfg_data = '0;
  logic                         item_valid = 1'b0;
  logic                         item_stall;
  logic                         op = bsw_pkg::OP_START;
  logic [7:0]                   source_byte = '0;
  logic                         result_valid;
  logic                         result_stall = 1'b0;
  logic                         pixel_valid;
  logic [7:0]                   color;
  logic [11:0]                  dest_x;
  logic [11:0]                  dest_y;
  logic [11:0]                  fetch_row;
  logic [11:0]                  fetch_byte;
  logic                         last;

  bitmap_stretch_pixel_walker #(
    .COORD_BITS(12)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .op(op),
    .source_byte(source_byte),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .pixel_valid(pixel_valid),
    .color(color),
    .dest_x(dest_x),
    .dest_y(dest_y),
    .fetch_row(fetch_row),
    .fetch_byte(fetch_byte),
    .last(last)
  );

  // The clock has a period of 4 ns.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copies of the configuration registers, holding their reset values.
  logic [11:0]        reg_src_width     = 12'd1;
  logic [11:0]        reg_src_height    = 12'd1;
  logic [11:0]        reg_bitmap_height = 12'd1;
  logic signed [12:0] reg_dst_width     = 13'sd1;
  logic signed [12:0] reg_dst_height    = 13'sd1;
  logic [11:0]        reg_src_x         = 12'd0;
  logic [11:0]        reg_src_y         = 12'd0;
  logic [1:0]         reg_pixel_format  = bsw_pkg::FMT_8BPP;

  // The predicted walk state. Positions and error terms are kept as plain integers,
  // which is wide enough for every reachable value.
  int  walk_col       = 0;
  int  walk_row       = 0;
  int  rows_remaining = 0;
  int  err_x          = 0;
  int  err_y          = 0;
  int  px_x           = 0;
  int  px_y           = 0;
  bit  walking        = 1'b0;

  // Setup latched by the most recent start transaction.
  int         lat_dw   = 0;
  int         lat_dh   = 0;
  int         lat_sw2  = 0;
  int         lat_sh2  = 0;
  int         lat_col0 = 0;
  int         lat_xdir = 1;
  int         lat_ydir = 1;
  logic [1:0] lat_fmt  = bsw_pkg::FMT_1BPP;

  pixel_result_t expected_pixels[$];
  int            error_count  = 0;
  int            results_seen = 0;
  int            quiet_cycles = 0;
  int            result_hold  = 0;
  bit            sender_idles = 1'b1;
  bit            result_idles = 1'b1;

  function automatic logic [11:0] clamp_coord(int v);
    if (v < 0) return 12'd0;
    if (v > COORD_MAX) return 12'(COORD_MAX);
    return 12'(v);
  endfunction

  // The fetch position is the byte that holds the current source column, in the row
  // currently walked. Both saturate at the coordinate range.
  function automatic void fill_fetch(inout pixel_result_t r);
    int c;
    c = (walk_col < 0) ? 0 : walk_col;
    if (lat_fmt == bsw_pkg::FMT_1BPP) begin
      c = c >>> 3;
    end else if (lat_fmt == bsw_pkg::FMT_4BPP) begin
      c = c >>> 1;
    end
    r.fetch_row  = clamp_coord(walk_row);
    r.fetch_byte = clamp_coord(c);
  endfunction

  // Advances the predicted walk by one input transaction and returns its result.
  function automatic pixel_result_t stretch_step(logic item_op, logic [7:0] sb);
    pixel_result_t r;
    bit            x_mirror;
    bit            y_mirror;
    bit            finished;
    int            steps;
    int            c;
    r = '0;
    finished = 1'b0;

    if (item_op == bsw_pkg::OP_START) begin
      x_mirror = (reg_dst_width < 0);
      y_mirror = (reg_dst_height < 0);
      lat_dw   = x_mirror ? -int'(reg_dst_width) : int'(reg_dst_width);
      lat_dh   = y_mirror ? -int'(reg_dst_height) : int'(reg_dst_height);
      lat_sw2  = 2 * int'(reg_src_width);
      lat_sh2  = 2 * int'(reg_src_height);
      // A mirrored x axis walks columns downward; a mirrored y axis walks the
      // bottom-up storage upward.
      lat_xdir = x_mirror ? -1 : 1;
      lat_ydir = y_mirror ? 1 : -1;
      lat_fmt  = reg_pixel_format;
      lat_col0 = x_mirror ? int'(reg_src_width) - int'(reg_src_x) - 1 : int'(reg_src_x);
      if (lat_col0 < 0) begin
        lat_col0 = 0;
      end
      walk_col       = lat_col0;
      walk_row       = y_mirror ? int'(reg_src_y)
                                : int'(reg_bitmap_height) - 1 - int'(reg_src_y);
      rows_remaining = int'(reg_src_height);
      err_x          = lat_sw2 - lat_dw;
      err_y          = lat_sh2 - lat_dh;
      px_x           = 0;
      px_y           = 0;
      walking        = (lat_dw != 0) && (lat_dh != 0);
      if (walking) begin
        fill_fetch(r);
      end
      return r;
    end

    // A pixel transaction with no walk running gives an all-zero result.
    if (!walking) begin
      return r;
    end

    r.pixel_valid = 1'b1;
    c = (walk_col < 0) ? 0 : walk_col;
    case (lat_fmt)
      bsw_pkg::FMT_1BPP: begin
        r.color = ((sb & (8'h80 >> c[2:0])) != 8'h00) ? 8'h0F : 8'h00;
      end
      bsw_pkg::FMT_4BPP: begin
        r.color = (c[0] ? sb : (sb >> 4)) & 8'h0F;
      end
      default: begin
        r.color = sb;
      end
    endcase
    r.dest_x = 12'(px_x);
    r.dest_y = 12'(px_y);

    // Skip as many source columns as the x error term has built up.
    if (err_x >= 0) begin
      steps = err_x / (2 * lat_dw) + 1;
      walk_col += lat_xdir * steps;
      if (walk_col < 0) begin
        walk_col = 0;
      end
      err_x -= steps * 2 * lat_dw;
    end
    err_x += lat_sw2;
    px_x++;

    // At the end of a destination row, consume source rows the same way. Running out
    // of source rows or of destination rows ends the walk.
    if (px_x >= lat_dw) begin
      if (err_y >= 0) begin
        steps = err_y / (2 * lat_dh) + 1;
        if (rows_remaining <= steps) begin
          finished = 1'b1;
        end else begin
          rows_remaining -= steps;
          walk_row += lat_ydir * steps;
          err_y -= steps * 2 * lat_dh;
        end
      end
      if (!finished) begin
        err_y += lat_sh2;
        px_y++;
        if (px_y >= lat_dh) begin
          finished = 1'b1;
        end
      end
      px_x     = 0;
      walk_col = lat_col0;
      err_x    = lat_sw2 - lat_dw;
    end

    if (finished) begin
      walking = 1'b0;
      r.last  = 1'b1;
    end else begin
      fill_fetch(r);
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    error_count++;
    $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [11:0] got, logic [11:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                results_seen, name, got, want));
    end
  endtask

  // Sends one input transaction and records its predicted result once it is accepted.
  // The valid is lowered only when a gap follows, so a back-to-back item never sees
  // the valid dropped and raised in the same time step.
  task automatic send_item(logic item_op, logic [7:0] sb);
    int gap;
    gap = sender_idles ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid  <= 1'b1;
    op          <= item_op;
    source_byte <= sb;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    expected_pixels.push_back(stretch_step(item_op, sb));
  endtask

  // Holds the sender back until every outstanding result has been received.
  task automatic wait_for_results();
    item_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes one register; the write enable stays high so that writes can follow
  // back to back, and the caller lowers it afterwards.
  task automatic write_reg(logic [bsw_pkg::CfgIdxW-1:0] idx, int value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= bsw_pkg::CfgDataW'(value);
    @(posedge clk);
    case (idx)
      bsw_pkg::REG_SRC_WIDTH:     reg_src_width     = 12'(value);
      bsw_pkg::REG_SRC_HEIGHT:    reg_src_height    = 12'(value);
      bsw_pkg::REG_BITMAP_HEIGHT: reg_bitmap_height = 12'(value);
      bsw_pkg::REG_DST_WIDTH:     reg_dst_width     = 13'(value);
      bsw_pkg::REG_DST_HEIGHT:    reg_dst_height    = 13'(value);
      bsw_pkg::REG_SRC_X:         reg_src_x         = 12'(value);
      bsw_pkg::REG_SRC_Y:         reg_src_y         = 12'(value);
      default:                    reg_pixel_format  = 2'(value);
    endcase
  endtask

  // Reprograms the whole geometry, but only once the block has gone quiet.
  task automatic apply_geometry(int sw, int sh, int bh, int dw, int dh,
                                int sx, int sy, int fmt);
    wait_for_results();
    write_reg(bsw_pkg::REG_SRC_WIDTH, sw);
    write_reg(bsw_pkg::REG_SRC_HEIGHT, sh);
    write_reg(bsw_pkg::REG_BITMAP_HEIGHT, bh);
    write_reg(bsw_pkg::REG_DST_WIDTH, dw);
    write_reg(bsw_pkg::REG_DST_HEIGHT, dh);
    write_reg(bsw_pkg::REG_SRC_X, sx);
    write_reg(bsw_pkg::REG_SRC_Y, sy);
    write_reg(bsw_pkg::REG_PIXEL_FORMAT, fmt);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // A size in 1..hi that favors both ends of the range.
  function automatic int pick_span(int hi);
    case ($urandom_range(0, 3))
      0:       return 1;
      1:       return hi;
      default: return $urandom_range(1, hi);
    endcase
  endfunction

  // A destination extent of either sign, now and then zero.
  function automatic int pick_extent(int hi);
    int v;
    v = pick_span(hi);
    if ($urandom_range(0, 15) == 0) return 0;
    return ($urandom_range(0, 1) != 0) ? -v : v;
  endfunction

  // Offsets do not lengthen the loops, so the full range is drawn here, with the edges favored.
  function automatic int pick_coord();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return COORD_MAX;
      2:       return $urandom_range(0, COORD_MAX);
      default: return $urandom_range(0, 15);
    endcase
  endfunction

  function automatic int pick_format();
    if ($urandom_range(0, 9) == 0) return FMT_RESERVED;
    return $urandom_range(0, 2);
  endfunction

  // The registers still hold their reset values here: a one-pixel, eight-bit walk.
  // Pixel transactions before the start and after the end find no walk running.
  task automatic test_reset_state();
    send_item(bsw_pkg::OP_PIXEL, 8'hFF);
    send_item(bsw_pkg::OP_START, 8'h00);
    send_item(bsw_pkg::OP_PIXEL, 8'hFF);
    send_item(bsw_pkg::OP_PIXEL, 8'h00);
  endtask

  // One-bit and four-bit unpacking, and the reserved format code.
  task automatic test_pixel_formats();
    apply_geometry(8, 2, 4, 8, 2, 3, 1, bsw_pkg::FMT_1BPP);
    send_item(bsw_pkg::OP_START, 8'h00);
    send_item(bsw_pkg::OP_PIXEL, 8'hA5);
    send_item(bsw_pkg::OP_PIXEL, 8'h5A);
    apply_geometry(8, 2, 4, 8, 2, 3, 1, bsw_pkg::FMT_4BPP);
    send_item(bsw_pkg::OP_START, 8'hFF);
    send_item(bsw_pkg::OP_PIXEL, 8'hA5);
    send_item(bsw_pkg::OP_PIXEL, 8'h5A);
    apply_geometry(8, 2, 4, 8, 2, 3, 1, FMT_RESERVED);
    send_item(bsw_pkg::OP_START, 8'h00);
    send_item(bsw_pkg::OP_PIXEL, 8'hC3);
  endtask

  // Both axes mirrored with a first column below zero and a first row at the top of the
  // coordinate range, then a bottom-up walk whose first row falls below zero.
  task automatic test_mirror_and_clamp();
    apply_geometry(2, 4, 3, -3, -2, 9, COORD_MAX, bsw_pkg::FMT_8BPP);
    send_item(bsw_pkg::OP_START, 8'h00);
    send_item(bsw_pkg::OP_PIXEL, 8'h11);
    send_item(bsw_pkg::OP_PIXEL, 8'h22);
    send_item(bsw_pkg::OP_PIXEL, 8'h33);
    apply_geometry(4, 2, 3, 4, 2, 0, 10, bsw_pkg::FMT_4BPP);
    send_item(bsw_pkg::OP_START, 8'h00);
    send_item(bsw_pkg::OP_PIXEL, 8'hFF);
  endtask

  // A zero destination width or height leaves the walk idle.
  task automatic test_empty_destination();
    apply_geometry(4, 4, 4, 0, 3, 0, 0, bsw_pkg::FMT_8BPP);
    send_item(bsw_pkg::OP_START, 8'h00);
    send_item(bsw_pkg::OP_PIXEL, 8'hFF);
    apply_geometry(4, 4, 4, 5, 0, 0, 0, bsw_pkg::FMT_8BPP);
    send_item(bsw_pkg::OP_START, 8'hFF);
  endtask

  // With no source rows the first destination row is still produced.
  task automatic test_zero_source_height();
    apply_geometry(3, 0, 2, 2, 2, 0, 0, bsw_pkg::FMT_1BPP);
    send_item(bsw_pkg::OP_START, 8'h00);
    send_item(bsw_pkg::OP_PIXEL, 8'h80);
    send_item(bsw_pkg::OP_PIXEL, 8'h40);
  endtask

  // The largest horizontal shrink, on a full-size source, and the largest horizontal stretch.
  task automatic test_extreme_sizes();
    apply_geometry(COORD_MAX, COORD_MAX, COORD_MAX, 1, -COORD_MAX, COORD_MAX, 0,
                   bsw_pkg::FMT_1BPP);
    send_item(bsw_pkg::OP_START, 8'h00);
    send_item(bsw_pkg::OP_PIXEL, 8'hFF);
    apply_geometry(1, 1, COORD_MAX, -COORD_MAX, COORD_MAX, 0, COORD_MAX,
                   bsw_pkg::FMT_8BPP);
    send_item(bsw_pkg::OP_START, 8'hFF);
    send_item(bsw_pkg::OP_PIXEL, 8'h00);
  endtask

  // Mostly well-formed walks with random source bytes: a start followed by pixels until
  // the walk ends or a cap is hit. Some walks carry random op noise that restarts them
  // midway, and some are followed by pixels sent after the walk has ended. Large
  // geometries are rare and short, since their loops run long.
  task automatic test_random_walks();
    int walk_items;
    int walks;
    int pixels;
    int cap;
    int kind;
    bit big;
    walk_items = 0;
    while (walk_items < RANDOM_ITEMS) begin
      big = ($urandom_range(0, 11) == 0);
      apply_geometry(pick_span(big ? COORD_MAX : 16), pick_span(big ? COORD_MAX : 8),
                     pick_span(($urandom_range(0, 1) != 0) ? COORD_MAX : 16),
                     pick_extent(big ? COORD_MAX : 16), pick_extent(big ? COORD_MAX : 8),
                     pick_coord(), pick_coord(), pick_format());
      // About one phase in four runs with no idling on either side.
      sender_idles = ($urandom_range(0, 3) != 0);
      result_idles = sender_idles;
      walks = big ? 1 : $urandom_range(1, 3);
      cap   = big ? 4 : 64;
      repeat (walks) begin
        kind = $urandom_range(0, 9);
        send_item(bsw_pkg::OP_START, 8'($urandom));
        walk_items++;
        pixels = 0;
        while (walking && pixels < cap) begin
          if (kind == 0 && $urandom_range(0, 5) == 0) begin
            send_item(1'($urandom_range(0, 1)), 8'($urandom));
          end else begin
            send_item(bsw_pkg::OP_PIXEL, 8'($urandom));
          end
          pixels++;
          walk_items++;
        end
        if (kind == 1) begin
          repeat ($urandom_range(1, 3)) send_item(bsw_pkg::OP_PIXEL, 8'($urandom));
        end
        // Now and then the sender waits for the result channel to empty completely.
        if ($urandom_range(0, 7) == 0) begin
          wait_for_results();
        end
      end
    end
    sender_idles = 1'b1;
    result_idles = 1'b1;
  endtask

  // Every accepted result is compared field by field with the oldest prediction.
  // After each result the receiver draws how many cycles it stalls.
  always @(posedge clk) begin : check_results
    pixel_result_t got;
    pixel_result_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        got = {pixel_valid, color, dest_x, dest_y, fetch_row, fetch_byte, last};
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no transaction pending",
                                    results_seen));
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_valid", 12'(got.pixel_valid), 12'(want.pixel_valid));
          check_field("color", 12'(got.color), 12'(want.color));
          check_field("dest_x", got.dest_x, want.dest_x);
          check_field("dest_y", got.dest_y, want.dest_y);
          check_field("fetch_row", got.fetch_row, want.fetch_row);
          check_field("fetch_byte", got.fetch_byte, want.fetch_byte);
          check_field("last", 12'(got.last), 12'(want.last));
        end
        results_seen++;
        result_hold = result_idles ? $urandom_range(0, 15) : 0;
      end else if (result_hold > 0) begin
        result_hold--;
      end
      result_stall <= (result_hold != 0);
    end
  end

  // The watchdog ends a run in which no transaction has been accepted for too long.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_pixel_formats();
    test_mirror_and_clamp();
    test_empty_destination();
    test_zero_source_height();
    test_extreme_sizes();
    test_random_walks();
    wait_for_results();
    // A further wait lets any stray result show up before the verdict.
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
